// ----- rtl/core/pattern_loop_flow_control_macros.svh -----
// ----------------------------------------------------------------------------
// pattern_loop_flow_control_macros
// Assertion shorthands for the pattern-loop flow controller. They expect the
// clock i_clk and the active-low reset i_rst_n in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef PATTERN_LOOP_FLOW_CONTROL_MACROS_SVH
`define PATTERN_LOOP_FLOW_CONTROL_MACROS_SVH

// Check a condition in the same cycle as its trigger
`define PLFC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger
`define PLFC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/plfc_pkg.sv -----
// ----------------------------------------------------------------------------
// plfc_pkg
// Shared types and constants of the pattern-loop flow controller.
// ----------------------------------------------------------------------------
`default_nettype none

package plfc_pkg;

    // Default sizing
    localparam int DEF_MAX_CHANNELS = 64;
    localparam int DEF_ROW_BITS     = 8;

    // Stream and configuration widths
    localparam int IN_DATA_W   = 24;
    localparam int IN_USER_W   = 1;
    localparam int OUT_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int CH_IN_W     = 6;
    localparam int CH_IN_RANGE = 64;
    localparam int COUNT_W     = 8;
    localparam int TALLY_W     = 8;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FLOW_FLAGS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_JUMP_QUIRK  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANS_InUSE = 2'd2;

    // Configuration reset values
    localparam logic [7:0] RST_FLOW_FLAGS = 8'd0;
    localparam logic [6:0] RST_CHANS      = 7'd4;

    // Bit positions inside flow_flags
    localparam int FLAG_FIRST_ONLY = 0;
    localparam int FLAG_SH_TARGET  = 1;
    localparam int FLAG_SH_COUNT   = 2;
    localparam int FLAG_IGNORE     = 3;
    localparam int FLAG_SAMEROW    = 4;
    localparam int FLAG_ADVANCE    = 5;
    localparam int FLAG_CANCEL     = 6;
    localparam int FLAG_EXCLUSIVE  = 7;

    // Input item kind carried on tuser
    localparam logic MODE_ROW_START = 1'b0;

    // Tally saturation limits
    localparam logic signed [TALLY_W-1:0] TALLY_MAX = 8'sd127;
    localparam logic signed [TALLY_W-1:0] TALLY_MIN = -8'sd128;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOOK = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    // Sequencer to scan unit
    typedef struct packed {
        logic go;
    } t_scan_ctl;

    // Scan unit to sequencer
    typedef struct packed {
        logic done;
        logic blocked;
    } t_scan_sts;

endpackage

`default_nettype wire

// ----- rtl/core/plfc_ram.sv -----
// ----------------------------------------------------------------------------
// plfc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module plfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/plfc_scan.sv -----
// ----------------------------------------------------------------------------
// plfc_scan
// Exclusive-loop scan: walks the per-channel count RAM one address a cycle
// and reports whether any other channel still has a loop counting.
// ----------------------------------------------------------------------------
`default_nettype none

module plfc_scan #(
    parameter int MAX_CHANNELS = plfc_pkg::DEF_MAX_CHANNELS,
    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
    localparam int IW = $clog2(MAX_CHANNELS + 1)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire plfc_pkg::t_scan_ctl          i_ctl,
    input  wire logic [AW-1:0]                i_ch,
    input  wire logic [IW-1:0]                i_count_n,
    input  wire logic [MAX_CHANNELS-1:0]      i_cnt_vld,
    input  wire logic [plfc_pkg::COUNT_W-1:0] i_rd_count,
    output logic      [AW-1:0]                o_addr,
    output plfc_pkg::t_scan_sts               o_sts
);

    import plfc_pkg::*;

    logic          r_busy;
    logic [IW-1:0] r_idx;
    logic          r_chk_vld;
    logic [AW-1:0] r_chk_idx;
    logic          r_chk_cv;
    logic          w_issue;
    logic          w_hit;
    logic          w_done;

    // Issue one address per cycle until the channel count is reached
    assign w_issue = r_busy && (r_idx < i_count_n);
    assign o_addr  = r_idx[AW-1:0];

    // Compare the count that returns from the previous address
    assign w_hit  = r_chk_vld && r_chk_cv && (r_chk_idx != i_ch) && (i_rd_count != '0);
    assign w_done = r_busy && (w_hit || (!w_issue && !r_chk_vld));

    assign o_sts.done    = w_done;
    assign o_sts.blocked = w_hit;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_chk_vld <= 1'b0;
        end else if (i_ctl.go) begin
            r_busy    <= 1'b1;
            r_chk_vld <= 1'b0;
        end else begin
            if (w_done) begin
                r_busy <= 1'b0;
            end
            r_chk_vld <= w_issue && !w_done;
        end
    end

    // Index and in-flight address tag
    always_ff @(posedge i_clk) begin
        if (i_ctl.go) begin
            r_idx <= '0;
        end else if (w_issue) begin
            r_idx     <= r_idx + IW'(1);
            r_chk_idx <= r_idx[AW-1:0];
            r_chk_cv  <= i_cnt_vld[r_idx[AW-1:0]];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/pattern_loop_flow_control.sv -----
// Flow: a row start or a first-only drop goes from IDLE to DONE, then to the output
//   register; other effects also pass LOOK, an exclusive-rule arm LOOK and then SCAN.
// Items: a new item is taken only in IDLE, after the last result is loaded; the count RAM
//   read port sets the scan at one channel count per cycle.
// Reset: synchronous active low; valid bits make all loop state read as cleared
//   at once, no clearing pass; configuration returns to flags 0, quirk 0, 4 chans.
// ----------------------------------------------------------------------------
// pattern_loop_flow_control
// Pattern-loop flow controller: sequencer, loop state and per-channel RAMs.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pattern_loop_flow_control_macros.svh"

module pattern_loop_flow_control #(
    parameter int MAX_CHANNELS = plfc_pkg::DEF_MAX_CHANNELS,
    parameter int ROW_BITS     = plfc_pkg::DEF_ROW_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Input stream
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // tdata: channel[5:0], row[13:6], param[21:14], zero[23:22]
    input  wire logic [plfc_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // tuser: mode[0]
    input  wire logic [plfc_pkg::IN_USER_W-1:0]   i_s_axis_tuser,
    // Result stream
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // tdata: loop_target[9:0], jump_row[18:10], active_loops[26:19],
    //        effect_taken[27], zero[31:28]
    output logic      [plfc_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // Configuration writes
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [plfc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [plfc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import plfc_pkg::*;

    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int IW = $clog2(MAX_CHANNELS + 1);
    localparam int CW = (IW > 7) ? IW : 7;
    localparam int SW = ROW_BITS + 2;
    localparam int JW = ROW_BITS + 1;

    // Configuration
    logic [7:0] r_flags;
    logic       r_quirk;
    logic [6:0] r_chans;

    // Sequencer and item registers
    t_state               r_state, n_state;
    logic [AW-1:0]        r_ch;
    logic [ROW_BITS-1:0]  r_row;
    logic [COUNT_W-1:0]   r_param;
    logic                 r_taken, n_taken;
    logic signed [SW-1:0] r_s1, n_s1;

    // Loop state
    logic signed [SW-1:0]      r_sh_start, n_sh_start;
    logic [COUNT_W-1:0]        r_sh_cnt, n_sh_cnt;
    logic                      r_seen, n_seen;
    logic signed [SW-1:0]      r_pend_tgt, n_pend_tgt;
    logic signed [JW-1:0]      r_pend_jmp, n_pend_jmp;
    logic signed [TALLY_W-1:0] r_tally, n_tally;
    logic [MAX_CHANNELS-1:0]   r_st_vld;
    logic [MAX_CHANNELS-1:0]   r_ct_vld;

    // Output register
    logic                  r_out_vld;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  w_out_load;

    // Datapath nets
    logic [AW-1:0]        w_mod_tab [CH_IN_RANGE];
    logic                 w_in_acc;
    logic [AW-1:0]        w_in_ch;
    logic [ROW_BITS-1:0]  w_in_row;
    logic [AW-1:0]        w_rd_addr;
    logic [SW-1:0]        w_st_rd;
    logic [COUNT_W-1:0]   w_ct_rd;
    logic signed [SW-1:0] w_s;
    logic [COUNT_W-1:0]   w_c;
    logic [COUNT_W-1:0]   w_c1;
    logic signed [SW-1:0] w_row_s;
    logic signed [SW-1:0] w_s1;
    logic [CW-1:0]        w_cin;
    logic [IW-1:0]        w_count_n;
    logic signed [9:0]    w_out_tgt;
    logic signed [8:0]    w_out_jmp;

    // Write requests from the sequencer
    logic                 l_st_wr;
    logic signed [SW-1:0] l_st_val;
    logic                 l_ct_wr;
    logic [COUNT_W-1:0]   l_ct_val;
    logic                 l_up;
    logic                 l_dn;
    logic                 w_st_we;
    logic                 w_ct_we;

    // Scan unit link
    t_scan_ctl     w_scan_ctl;
    t_scan_sts     w_scan_sts;
    logic [AW-1:0] w_scan_addr;

    // Channel modulo table, worked out at elaboration
    for (genvar g = 0; g < CH_IN_RANGE; g++) begin : g_mod
        assign w_mod_tab[g] = AW'(g % MAX_CHANNELS);
    end

    // Unpack the input transfer
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_ch         = w_mod_tab[i_s_axis_tdata[CH_IN_W-1:0]];
    assign w_in_row        = ROW_BITS'(i_s_axis_tdata[13:6]);

    // Current start and count of the selected slot
    assign w_s     = r_flags[FLAG_SH_TARGET] ? r_sh_start
                   : (r_st_vld[r_ch] ? $signed(w_st_rd) : '1);
    assign w_c     = r_flags[FLAG_SH_COUNT] ? r_sh_cnt
                   : (r_ct_vld[r_ch] ? w_ct_rd : '0);
    assign w_c1    = w_c - COUNT_W'(1);
    assign w_row_s = {2'b00, r_row};
    assign w_s1    = (w_s < 0) ? (r_flags[FLAG_SAMEROW] ? w_row_s : '0) : w_s;

    // Channels covered by the exclusive rule
    assign w_cin     = CW'(r_chans);
    assign w_count_n = (w_cin > CW'(MAX_CHANNELS)) ? IW'(MAX_CHANNELS) : IW'(w_cin);

    assign w_rd_addr = (r_state == S_SCAN) ? w_scan_addr : w_in_ch;

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_taken    = r_taken;
        n_s1       = r_s1;
        n_seen     = r_seen;
        n_pend_tgt = r_pend_tgt;
        n_pend_jmp = r_pend_jmp;
        l_st_wr    = 1'b0;
        l_st_val   = w_s1;
        l_ct_wr    = 1'b0;
        l_ct_val   = r_param;
        l_up       = 1'b0;
        l_dn       = 1'b0;
        w_scan_ctl = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_taken = 1'b0;
                    if (i_s_axis_tuser[0] == MODE_ROW_START) begin
                        n_seen     = 1'b0;
                        n_pend_tgt = '1;
                        n_state    = S_DONE;
                    end else if (r_flags[FLAG_FIRST_ONLY] && r_seen) begin
                        n_state = S_DONE;
                    end else begin
                        n_seen  = 1'b1;
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                n_state = S_DONE;
                if (r_param == '0) begin
                    // Start mark
                    if (!(r_flags[FLAG_IGNORE] && (w_c != '0))) begin
                        l_st_wr  = 1'b1;
                        l_st_val = w_row_s;
                        if (r_quirk) begin
                            n_pend_jmp = {1'b0, r_row};
                        end
                        n_taken = 1'b1;
                    end
                end else if (w_c != '0) begin
                    // Count down, or end the loop
                    l_ct_wr  = 1'b1;
                    l_ct_val = w_c1;
                    l_st_wr  = 1'b1;
                    n_taken  = 1'b1;
                    if (w_c1 != '0) begin
                        n_pend_tgt = w_s1;
                    end else begin
                        if (r_flags[FLAG_ADVANCE]) begin
                            l_st_val = w_row_s + SW'(1);
                        end
                        if (r_flags[FLAG_CANCEL]) begin
                            n_pend_tgt = '1;
                        end
                        l_dn = 1'b1;
                    end
                end else if (r_flags[FLAG_EXCLUSIVE]) begin
                    // Arm only after the scan finds no other loop
                    l_st_wr       = 1'b1;
                    n_s1          = w_s1;
                    w_scan_ctl.go = 1'b1;
                    n_state       = S_SCAN;
                end else begin
                    l_st_wr    = 1'b1;
                    l_ct_wr    = 1'b1;
                    n_pend_tgt = w_s1;
                    l_up       = 1'b1;
                    n_taken    = 1'b1;
                end
            end
            S_SCAN: begin
                if (w_scan_sts.done) begin
                    n_state = S_DONE;
                    if (!w_scan_sts.blocked) begin
                        l_ct_wr    = 1'b1;
                        n_pend_tgt = r_s1;
                        l_up       = 1'b1;
                        n_taken    = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Route writes to the shared pair or to the channel RAMs
    always_comb begin
        n_sh_start = r_sh_start;
        n_sh_cnt   = r_sh_cnt;
        w_st_we    = 1'b0;
        w_ct_we    = 1'b0;
        if (l_st_wr) begin
            if (r_flags[FLAG_SH_TARGET]) begin
                n_sh_start = l_st_val;
            end else begin
                w_st_we = 1'b1;
            end
        end
        if (l_ct_wr) begin
            if (r_flags[FLAG_SH_COUNT]) begin
                n_sh_cnt = l_ct_val;
            end else begin
                w_ct_we = 1'b1;
            end
        end
    end

    // Saturating tally
    always_comb begin
        n_tally = r_tally;
        if (l_up && (r_tally != TALLY_MAX)) begin
            n_tally = r_tally + TALLY_W'(1);
        end else if (l_dn && (r_tally != TALLY_MIN)) begin
            n_tally = r_tally - TALLY_W'(1);
        end
    end

    // Configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= RST_FLOW_FLAGS;
            r_quirk <= 1'b0;
            r_chans <= RST_CHANS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FLOW_FLAGS:  r_flags <= i_cfg_data;
                CFG_JUMP_QUIRK:  r_quirk <= i_cfg_data[0];
                CFG_CHANS_InUSE: r_chans <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Control and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_sh_start <= '1;
            r_sh_cnt   <= '0;
            r_seen     <= 1'b0;
            r_pend_tgt <= '1;
            r_pend_jmp <= '1;
            r_tally    <= '0;
            r_st_vld   <= '0;
            r_ct_vld   <= '0;
        end else begin
            r_state    <= n_state;
            r_sh_start <= n_sh_start;
            r_sh_cnt   <= n_sh_cnt;
            r_seen     <= n_seen;
            r_pend_tgt <= n_pend_tgt;
            r_pend_jmp <= n_pend_jmp;
            r_tally    <= n_tally;
            if (w_st_we) begin
                r_st_vld[r_ch] <= 1'b1;
            end
            if (w_ct_we) begin
                r_ct_vld[r_ch] <= 1'b1;
            end
        end
    end

    // Item payload
    always_ff @(posedge i_clk) begin
        r_taken <= n_taken;
        r_s1    <= n_s1;
        if (w_in_acc) begin
            r_ch    <= w_in_ch;
            r_row   <= w_in_row;
            r_param <= i_s_axis_tdata[21:14];
        end
    end

    // Per-channel loop start and count
    plfc_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_CHANNELS)
    ) u_start_ram (
        .i_clk   (i_clk),
        .i_we    (w_st_we),
        .i_waddr (r_ch),
        .i_wdata (l_st_val),
        .i_raddr (w_rd_addr),
        .o_rdata (w_st_rd)
    );

    plfc_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (MAX_CHANNELS)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (w_ct_we),
        .i_waddr (r_ch),
        .i_wdata (l_ct_val),
        .i_raddr (w_rd_addr),
        .o_rdata (w_ct_rd)
    );

    // Exclusive-rule scan
    plfc_scan #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_scan_ctl),
        .i_ch       (r_ch),
        .i_count_n  (w_count_n),
        .i_cnt_vld  (r_ct_vld),
        .i_rd_count (w_ct_rd),
        .o_addr     (w_scan_addr),
        .o_sts      (w_scan_sts)
    );

    // Output register: load in DONE when free, drop on transfer
    assign w_out_load = (r_state == S_DONE) && (!r_out_vld || i_m_axis_tready);
    assign w_out_tgt  = 10'(r_pend_tgt);
    assign w_out_jmp  = 9'(r_pend_jmp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= {4'b0000, r_taken, r_tally, w_out_jmp, w_out_tgt};
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    // Assertions
    `PLFC_ASSERT_IMP(a_scan_done_in_scan, w_scan_sts.done, r_state == S_SCAN,
                     "scan finished outside SCAN")
    `PLFC_ASSERT_NXT(a_done_waits, (r_state == S_DONE) && r_out_vld && !i_m_axis_tready,
                     r_state == S_DONE, "left DONE with output still held")
    `PLFC_ASSERT_NXT(a_look_leaves, r_state == S_LOOK,
                     (r_state == S_DONE) || (r_state == S_SCAN), "LOOK did not resolve")
    `PLFC_ASSERT_IMP(a_scan_go_from_look, w_scan_ctl.go, r_state == S_LOOK,
                     "scan started outside LOOK")

endmodule

`default_nettype wire

// ----- verif/pattern_loop_flow_control_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pattern_loop_flow_control_tb
// Self-checking bench for the pattern-loop flow controller. A directed table
// walks row starts, loop marks, arms, countdowns and loop ends under several
// flag settings. Random rows of loop effects follow, with random idling on
// both streams, a long result back-pressure and a full drain. Every result is
// compared field by field against its typed table entry or an in-bench loop model.
// ----------------------------------------------------------------------------

module pattern_loop_flow_control_tb;

    import plfc_pkg::*;

    localparam int  N_CHANNELS     = DEF_MAX_CHANNELS;
    localparam logic MODE_LOOP_FX  = ~MODE_ROW_START;
    localparam int  RAND_PHASES    = 13;
    localparam int  PHASE_ITEMS    = 150;
    localparam int  HOLD_PHASE     = 8;
    localparam int  PAUSE_PHASE    = 9;
    localparam int  RX_HOLD_CYCLES = 400;
    localparam int  TAIL_CYCLES    = 80;
    localparam longint TIMEOUT_NS  = 64'd10_000_000;

    // Flow flag masks
    localparam logic [7:0] FL_FIRST  = 8'b1 << FLAG_FIRST_ONLY;
    localparam logic [7:0] FL_SH_TGT = 8'b1 << FLAG_SH_TARGET;
    localparam logic [7:0] FL_SH_CNT = 8'b1 << FLAG_SH_COUNT;
    localparam logic [7:0] FL_IGNORE = 8'b1 << FLAG_IGNORE;
    localparam logic [7:0] FL_SAME   = 8'b1 << FLAG_SAMEROW;
    localparam logic [7:0] FL_ADV    = 8'b1 << FLAG_ADVANCE;
    localparam logic [7:0] FL_CANCEL = 8'b1 << FLAG_CANCEL;
    localparam logic [7:0] FL_EXCL   = 8'b1 << FLAG_EXCLUSIVE;

    // One result, laid out as in the result tdata (loop_target lowest)
    typedef struct packed {
        logic       taken;
        logic [7:0] tally;
        logic [8:0] jump;
        logic [9:0] target;
    } t_loop_result;

    // One row of the directed table
    typedef struct packed {
        logic                   is_cfg;
        logic [CFG_INDEX_W-1:0] cfg_index;
        logic [CFG_DATA_W-1:0]  cfg_value;
        logic                   mode;
        logic [5:0]             channel;
        logic [7:0]             row;
        logic [7:0]             param;
        logic                   typed;
        t_loop_result           result;
    } t_dir_entry;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_DATA_W-1:0]   i_s_axis_tdata;
    logic [IN_USER_W-1:0]   i_s_axis_tuser;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_DATA_W-1:0]  o_m_axis_tdata;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    // Register shadows
    logic [7:0] flags_r;
    logic       quirk_r;
    logic [6:0] chans_r;

    // Loop state mirror
    logic signed [9:0] ch_start [N_CHANNELS];
    logic [7:0]        ch_count [N_CHANNELS];
    logic signed [9:0] sh_start;
    logic [7:0]        sh_count;
    logic              row_seen;
    logic signed [9:0] tgt_pending;
    logic signed [8:0] jump_pending;
    logic signed [7:0] tally;

    t_loop_result results_due [$];

    int tx_idle_pct;
    int rx_idle_pct;
    int hold_requests;
    int failures;
    int results_checked;
    int regs_written;

    pattern_loop_flow_control DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Advance the loop state by one item and return the result it shows
    function automatic t_loop_result next_loop_result(input logic mode, input logic [5:0] ch,
                                                      input logic [7:0] row,
                                                      input logic [7:0] param);
        t_loop_result      res;
        logic signed [9:0] start;
        logic [7:0]        count;
        logic              taken;
        logic              blocked;
        int                delta;
        int                sum;
        int                n;
        taken = 1'b0;
        delta = 0;
        if (mode == MODE_ROW_START) begin
            row_seen    = 1'b0;
            tgt_pending = -10'sd1;
        end else if (!(flags_r[FLAG_FIRST_ONLY] && row_seen)) begin
            row_seen = 1'b1;
            taken    = 1'b1;
            start    = flags_r[FLAG_SH_TARGET] ? sh_start : ch_start[ch];
            count    = flags_r[FLAG_SH_COUNT] ? sh_count : ch_count[ch];
            if (param == 8'd0) begin
                // Loop start mark, dropped while counting under the ignore rule
                if (flags_r[FLAG_IGNORE] && count != 8'd0) begin
                    taken = 1'b0;
                end else begin
                    start = $signed({2'b00, row});
                    if (quirk_r)
                        jump_pending = $signed({1'b0, row});
                end
            end else begin
                if (start[9])
                    start = flags_r[FLAG_SAMEROW] ? $signed({2'b00, row}) : 10'sd0;
                if (count != 8'd0) begin
                    // Count down, jump back or end the loop
                    count = count - 8'd1;
                    if (count != 8'd0) begin
                        tgt_pending = start;
                    end else begin
                        if (flags_r[FLAG_ADVANCE])
                            start = $signed({2'b00, row}) + 10'sd1;
                        if (flags_r[FLAG_CANCEL])
                            tgt_pending = -10'sd1;
                        delta = -1;
                    end
                end else begin
                    // Arm, unless another channel is counting under the exclusive rule
                    blocked = 1'b0;
                    n = (int'(chans_r) > N_CHANNELS) ? N_CHANNELS : int'(chans_r);
                    if (flags_r[FLAG_EXCLUSIVE]) begin
                        for (int i = 0; i < n; i++) begin
                            if (i != int'(ch) && ch_count[i] != 8'd0)
                                blocked = 1'b1;
                        end
                    end
                    if (blocked) begin
                        taken = 1'b0;
                    end else begin
                        count       = param;
                        tgt_pending = start;
                        delta       = 1;
                    end
                end
            end
            if (flags_r[FLAG_SH_TARGET])
                sh_start = start;
            else
                ch_start[ch] = start;
            if (flags_r[FLAG_SH_COUNT])
                sh_count = count;
            else
                ch_count[ch] = count;
            // Saturate the running tally
            sum = int'(tally) + delta;
            if (sum > 127)
                sum = 127;
            if (sum < -128)
                sum = -128;
            tally = sum[7:0];
        end
        res.target = tgt_pending;
        res.jump   = jump_pending;
        res.tally  = tally;
        res.taken  = taken;
        return res;
    endfunction

    function automatic t_dir_entry dir_item(input logic m, input logic [5:0] c,
                                            input logic [7:0] r, input logic [7:0] p);
        t_dir_entry e;
        e         = '0;
        e.mode    = m;
        e.channel = c;
        e.row     = r;
        e.param   = p;
        return e;
    endfunction

    function automatic t_dir_entry dir_checked(input logic m, input logic [5:0] c,
                                               input logic [7:0] r, input logic [7:0] p,
                                               input int target, input int jump,
                                               input int tl, input logic tk);
        t_dir_entry e;
        e               = dir_item(m, c, r, p);
        e.typed         = 1'b1;
        e.result.target = target[9:0];
        e.result.jump   = jump[8:0];
        e.result.tally  = tl[7:0];
        e.result.taken  = tk;
        return e;
    endfunction

    function automatic t_dir_entry dir_cfg(input logic [CFG_INDEX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] value);
        t_dir_entry e;
        e           = '0;
        e.is_cfg    = 1'b1;
        e.cfg_index = idx;
        e.cfg_value = value;
        return e;
    endfunction

    // Offer one item after random idle cycles, then record its result once accepted
    task automatic send_transfer(input logic mode, input logic [5:0] ch, input logic [7:0] row,
                                 input logic [7:0] param, input logic use_typed,
                                 input t_loop_result typed);
        t_loop_result predicted;
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, param, row, ch};
        i_s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predicted = next_loop_result(mode, ch, row, param);
        results_due.push_back(use_typed ? typed : predicted);
    endtask

    // Drop the input valid and hold until every result has come back
    task automatic wait_results_drained();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_FLOW_FLAGS:  flags_r = value;
            CFG_JUMP_QUIRK:  quirk_r = value[0];
            CFG_CHANS_InUSE: chans_r = value[6:0];
            default: ;
        endcase
        regs_written++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Result sink: random ready, with a long hold-off on request
    initial begin : result_sink
        int hold_left;
        int hold_seen;
        hold_left       = 0;
        hold_seen       = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Compare each result transfer with the oldest one due
    always @(posedge i_clk) begin : result_check
        t_loop_result want;
        t_loop_result got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata[27:0];
            if (results_due.size() == 0) begin
                $error("unexpected result transfer, tdata %h", o_m_axis_tdata);
                failures++;
            end else begin
                want = results_due.pop_front();
                results_checked++;
                if (got.target !== want.target) begin
                    $error("loop_target: expected %0d, actual %0d",
                           $signed(want.target), $signed(got.target));
                    failures++;
                end
                if (got.jump !== want.jump) begin
                    $error("jump_row: expected %0d, actual %0d",
                           $signed(want.jump), $signed(got.jump));
                    failures++;
                end
                if (got.tally !== want.tally) begin
                    $error("active_loops: expected %0d, actual %0d",
                           $signed(want.tally), $signed(got.tally));
                    failures++;
                end
                if (got.taken !== want.taken) begin
                    $error("effect_taken: expected %0d, actual %0d", want.taken, got.taken);
                    failures++;
                end
                if (o_m_axis_tdata[31:28] !== 4'd0) begin
                    $error("pad bits: expected 0, actual %0d", o_m_axis_tdata[31:28]);
                    failures++;
                end
            end
        end
    end

    // Stimulus
    initial begin : stimulus
        t_dir_entry dir_table [$];
        t_dir_entry e;
        logic [7:0] cur_row;
        logic [7:0] param;
        logic [5:0] ch;
        int         sent;
        int         pick;
        int         dir_items;
        int         rand_items;
        logic       paused;

        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        tx_idle_pct     = 9;
        rx_idle_pct     = 86;
        hold_requests   = 0;
        failures        = 0;
        results_checked = 0;
        regs_written    = 0;
        dir_items       = 0;
        rand_items      = 0;

        // Mirror the reset state
        flags_r = RST_FLOW_FLAGS;
        quirk_r = 1'b0;
        chans_r = RST_CHANS;
        for (int i = 0; i < N_CHANNELS; i++) begin
            ch_start[i] = -10'sd1;
            ch_count[i] = 8'd0;
        end
        sh_start     = -10'sd1;
        sh_count     = 8'd0;
        row_seen     = 1'b0;
        tgt_pending  = -10'sd1;
        jump_pending = -9'sd1;
        tally        = 8'sd0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset defaults, extreme channel, row and count
        dir_table.push_back(dir_checked(MODE_ROW_START, 6'd0, 8'd0, 8'd0, -1, -1, 0, 1'b0));
        dir_table.push_back(dir_checked(MODE_LOOP_FX, 6'd63, 8'd255, 8'd0, -1, -1, 0, 1'b1));
        dir_table.push_back(dir_checked(MODE_LOOP_FX, 6'd63, 8'd255, 8'd255, 255, -1, 1, 1'b1));
        dir_table.push_back(dir_item(MODE_LOOP_FX, 6'd63, 8'd10, 8'd1));
        dir_table.push_back(dir_checked(MODE_ROW_START, 6'd63, 8'd255, 8'd255, -1, -1, 1, 1'b0));
        dir_table.push_back(dir_item(MODE_LOOP_FX, 6'd0, 8'd0, 8'd1));
        dir_table.push_back(dir_item(MODE_LOOP_FX, 6'd0, 8'd5, 8'd1));
        // First-only, samerow, advance, cancel and the jump-row quirk
        dir_table.push_back(dir_cfg(CFG_FLOW_FLAGS, FL_FIRST | FL_SAME | FL_ADV | FL_CANCEL));
        dir_table.push_back(dir_cfg(CFG_JUMP_QUIRK, 8'd1));
        dir_table.push_back(dir_item(MODE_ROW_START, 6'd0, 8'd0, 8'd0));
        dir_table.push_back(dir_item(MODE_LOOP_FX, 6'd1, 8'd7, 8'd0));
        dir_table.push_back(dir_item(MODE_LOOP_FX, 6'd2, 8'd7, 8'd2));
        dir_table.push_back(dir_item(MODE_ROW_START, 6'd0, 8'd8, 8'd0));
        dir_table.push_back(dir_item(MODE_LOOP_FX, 6'd2, 8'd9, 8'd2));
        dir_table.push_back(dir_item(MODE_ROW_START, 6'd0, 8'd12, 8'd0));
        dir_table.push_back(dir_item(MODE_LOOP_FX, 6'd2, 8'd12, 8'd2));
        dir_table.push_back(dir_item(MODE_ROW_START, 6'd0, 8'd255, 8'd0));
        dir_table.push_back(dir_item(MODE_LOOP_FX, 6'd2, 8'd255, 8'd2));
        dir_table.push_back(dir_item(MODE_ROW_START, 6'd0, 8'd0, 8'd0));
        dir_table.push_back(dir_item(MODE_LOOP_FX, 6'd2, 8'd0, 8'd1));
        // Shared start and count, ignore and exclusive rules
        dir_table.push_back(dir_cfg(CFG_FLOW_FLAGS, FL_SH_TGT | FL_SH_CNT | FL_IGNORE | FL_EXCL));
        dir_table.push_back(dir_cfg(CFG_JUMP_QUIRK, 8'd0));
        dir_table.push_back(dir_cfg(CFG_CHANS_InUSE, 8'd64));
        dir_table.push_back(dir_item(MODE_LOOP_FX, 6'd5, 8'd20, 8'd4));
        dir_table.push_back(dir_cfg(CFG_CHANS_InUSE, 8'd1));
        dir_table.push_back(dir_item(MODE_LOOP_FX, 6'd0, 8'd21, 8'd4));
        dir_table.push_back(dir_item(MODE_LOOP_FX, 6'd7, 8'd30, 8'd0));
        // Every mode at once
        dir_table.push_back(dir_cfg(CFG_FLOW_FLAGS, 8'hFF));
        dir_table.push_back(dir_item(MODE_ROW_START, 6'd0, 8'd40, 8'd0));
        dir_table.push_back(dir_item(MODE_LOOP_FX, 6'd3, 8'd40, 8'd0));
        dir_table.push_back(dir_item(MODE_LOOP_FX, 6'd3, 8'd41, 8'd3));

        // Walk the table, writing registers only while the block is idle
        foreach (dir_table[k]) begin
            e = dir_table[k];
            if (e.is_cfg) begin
                wait_results_drained();
                write_register(e.cfg_index, e.cfg_value);
            end else begin
                send_transfer(e.mode, e.channel, e.row, e.param, e.typed, e.result);
                dir_items++;
            end
        end

        // Random rows of loop effects under a new setting per phase
        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p < 4) begin
                tx_idle_pct = 9;
                rx_idle_pct = 86;
            end else if (p < 8) begin
                tx_idle_pct = 86;
                rx_idle_pct = 9;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            wait_results_drained();
            write_register(CFG_FLOW_FLAGS, (p == 0) ? 8'h00 :
                                           (p == 1) ? 8'hFF : 8'($urandom_range(0, 255)));
            write_register(CFG_JUMP_QUIRK, 8'($urandom_range(0, 1)));
            write_register(CFG_CHANS_InUSE, (p % 3 == 0) ? 8'd1 :
                                            (p % 3 == 1) ? 8'd64 : 8'($urandom_range(1, 64)));
            if (p == HOLD_PHASE)
                hold_requests++;
            sent   = 0;
            paused = 1'b0;
            while (sent < PHASE_ITEMS) begin
                if (p == PAUSE_PHASE && !paused && sent >= PHASE_ITEMS / 2) begin
                    paused = 1'b1;
                    wait_results_drained();
                end
                cur_row = 8'($urandom_range(0, 255));
                // Mostly open the row; sometimes run effects on without a row start
                if ($urandom_range(99) >= 10) begin
                    send_transfer(MODE_ROW_START, 6'($urandom_range(0, 63)), cur_row,
                                  8'($urandom_range(0, 255)), 1'b0, '0);
                    sent++;
                end
                repeat ($urandom_range(1, 3)) begin
                    ch   = ($urandom_range(99) < 75) ? 6'($urandom_range(0, 7)) :
                                                       6'($urandom_range(0, 63));
                    pick = $urandom_range(99);
                    if (pick < 30)
                        param = 8'd0;
                    else if (pick < 85)
                        param = 8'($urandom_range(1, 3));
                    else
                        param = 8'($urandom_range(0, 255));
                    send_transfer(MODE_LOOP_FX, ch, cur_row, param, 1'b0, '0);
                    sent++;
                end
            end
            rand_items += sent;
        end

        // Drain and let the pipeline settle
        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d directed and %0d random items, %0d register writes,",
                 dir_items, rand_items, regs_written);
        $display("%0d results checked across idle, back-pressure and drain phases.",
                 results_checked);
        if (failures == 0 && results_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #(TIMEOUT_NS);
        $error("timeout with %0d results outstanding", results_due.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
